FILE: rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication violated");

`endif

FILE: rtl/cts_pkg.sv
// types, widths and constants for the taylor series cosine pipeline
`timescale 1ns / 1ps

package cts_pkg;

	localparam int ANGLE_W   = 32;
	localparam int COS_W     = 32;
	localparam int FRAC_W    = 32;
	localparam int X2_SH     = 24;
	localparam int X2_W      = 39;
	localparam int MAG_W     = 48;
	localparam int SUM_W     = 48;
	localparam int RECIP_W   = 32;
	localparam int MAX_TERMS = 11;
	localparam int HALF_W    = 24;
	localparam int XLO_W     = 20;
	localparam int XHI_W     = X2_W - XLO_W;
	localparam int PROD_W    = MAG_W + X2_W;
	localparam int RPROD_W   = MAG_W + RECIP_W;

	localparam logic [MAG_W-1:0] ONE_MAG = 48'h0001_0000_0000;

	localparam logic [SUM_W-1:0] SAT_HI_LIM = 48'h0001_FFFF_FFFE;
	localparam logic [SUM_W-1:0] SAT_LO_LIM = 48'hFFFE_0000_0000;
	localparam logic [COS_W-1:0] COS_MAX    = 32'h7FFF_FFFF;
	localparam logic [COS_W-1:0] COS_MIN    = 32'h8000_0000;

	typedef logic [RECIP_W-1:0] recip_t;

	// round(2^32 / ((2n-1)(2n)))
	localparam recip_t RECIP_TAB [MAX_TERMS] = '{
		32'd0,
		32'd2147483648,
		32'd357913941,
		32'd143165577,
		32'd76695845,
		32'd47721859,
		32'd32537631,
		32'd23598721,
		32'd17895697,
		32'd14035841,
		32'd11302546
	};

	typedef struct packed {
		logic              valid;
		logic [X2_W-1:0]   x2q;
		logic [MAG_W-1:0]  mag;
		logic [SUM_W-1:0]  sum;
	} term_bus_t;

endpackage

FILE: rtl/cosine_taylor_series.sv
// top level: pipelined cosine of a q4.28 angle by a truncated taylor series
// throughput: one request per cycle while angle_stall is low; each series term owns four pipeline stages
// an output register plus one skid entry let the pipe run while a result waits
// reset clears all valid bits and the skid; payload registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosine_taylor_series import cts_pkg::*; #(
	parameter int NUM_TERMS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      angle_valid,
	output logic                      angle_stall,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      cosine_valid,
	input  logic                      cosine_stall,
	output logic signed [COS_W-1:0]   cosine
);

	logic             en;
	logic             fin_valid;
	logic [COS_W-1:0] fin_cos;
	logic             take;
	logic             out_valid_q;
	logic [COS_W-1:0] out_q;
	logic             skid_valid_q;
	logic [COS_W-1:0] skid_q;

	term_bus_t chain [NUM_TERMS];

	assign en          = !skid_valid_q;
	assign angle_stall = skid_valid_q;

	cts_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (angle_valid),
		.angle    (angle),
		.bus_out  (chain[0])
	);

	for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
		cts_term #(
			.TERM_IDX (k)
		) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bus_in  (chain[k-1]),
			.bus_out (chain[k])
		);
	end

	cts_final #(
		.LAST_IDX (NUM_TERMS - 1)
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.bus_in    (chain[NUM_TERMS-1]),
		.out_valid (fin_valid),
		.cosine    (fin_cos)
	);

	assign take = out_valid_q && !cosine_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fin_valid) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (fin_valid) begin
			if (out_valid_q && !take) begin
				skid_q <= fin_cos;
			end else begin
				out_q <= fin_cos;
			end
		end
	end

	assign cosine_valid = out_valid_q;
	assign cosine       = out_q;

	`ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && !cosine_stall, !skid_valid_q)
	`ASSERT_NEXT(a_blocked_to_skid, clk, arst_n, out_valid_q && cosine_stall && fin_valid && !skid_valid_q, skid_valid_q)

endmodule

FILE: rtl/cts_prep.sv
// squares the angle and rounds it to an unsigned q.32 value
`timescale 1ns / 1ps

module cts_prep import cts_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [ANGLE_W-1:0] angle,
	output term_bus_t                 bus_out
);

	logic                   valid_s1;
	logic                   valid_s2;
	logic [2*ANGLE_W-1:0]   sq_s1;
	logic [2*ANGLE_W-1:0]   sq_rnd;
	logic [X2_W-1:0]        x2q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign sq_rnd = sq_s1 + ((2*ANGLE_W)'(1) << (X2_SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= $signed(angle) * $signed(angle);
			x2q_s2 <= sq_rnd[X2_SH +: X2_W];
		end
	end

	assign bus_out.valid = valid_s2;
	assign bus_out.x2q   = x2q_s2;
	assign bus_out.mag   = ONE_MAG;
	assign bus_out.sum   = '0;

endmodule

FILE: rtl/cts_term.sv
// one series term: adds the previous term, then scales it by x^2 and a reciprocal
`timescale 1ns / 1ps

module cts_term import cts_pkg::*; #(
	parameter int TERM_IDX = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  term_bus_t bus_in,
	output term_bus_t bus_out
);

	localparam recip_t RECIP    = RECIP_TAB[TERM_IDX];
	localparam bit     SUB_PREV = ((TERM_IDX - 1) % 2) == 1;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SUM_W-1:0]          sum_s1, sum_s2, sum_s3, sum_s4;
	logic [X2_W-1:0]           x2q_s1, x2q_s2, x2q_s3, x2q_s4;
	logic [HALF_W+XLO_W-1:0]   pp00_s1, pp10_s1;
	logic [HALF_W+XHI_W-1:0]   pp01_s1, pp11_s1;
	logic [PROD_W-1:0]         prod;
	logic [MAG_W-1:0]          mag_s2;
	logic [HALF_W+RECIP_W-1:0] q0_s3, q1_s3;
	logic [RPROD_W-1:0]        rprod;
	logic [MAG_W-1:0]          mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= bus_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign prod = PROD_W'(pp00_s1)
		+ (PROD_W'(pp01_s1) << XLO_W)
		+ (PROD_W'(pp10_s1) << HALF_W)
		+ (PROD_W'(pp11_s1) << (HALF_W + XLO_W))
		+ (PROD_W'(1) << (FRAC_W - 1));

	assign rprod = RPROD_W'(q0_s3)
		+ (RPROD_W'(q1_s3) << HALF_W)
		+ (RPROD_W'(1) << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: fold in previous term, partial products with x^2
			sum_s1  <= SUB_PREV ? (bus_in.sum - bus_in.mag) : (bus_in.sum + bus_in.mag);
			x2q_s1  <= bus_in.x2q;
			pp00_s1 <= bus_in.mag[HALF_W-1:0] * bus_in.x2q[XLO_W-1:0];
			pp01_s1 <= bus_in.mag[HALF_W-1:0] * bus_in.x2q[X2_W-1:XLO_W];
			pp10_s1 <= bus_in.mag[MAG_W-1:HALF_W] * bus_in.x2q[XLO_W-1:0];
			pp11_s1 <= bus_in.mag[MAG_W-1:HALF_W] * bus_in.x2q[X2_W-1:XLO_W];
			// stage 2: sum and round
			sum_s2  <= sum_s1;
			x2q_s2  <= x2q_s1;
			mag_s2  <= prod[FRAC_W +: MAG_W];
			// stage 3: partial products with the reciprocal
			sum_s3  <= sum_s2;
			x2q_s3  <= x2q_s2;
			q0_s3   <= mag_s2[HALF_W-1:0] * RECIP;
			q1_s3   <= mag_s2[MAG_W-1:HALF_W] * RECIP;
			// stage 4: sum and round
			sum_s4  <= sum_s3;
			x2q_s4  <= x2q_s3;
			mag_s4  <= rprod[FRAC_W +: MAG_W];
		end
	end

	assign bus_out.valid = valid_s4;
	assign bus_out.x2q   = x2q_s4;
	assign bus_out.mag   = mag_s4;
	assign bus_out.sum   = sum_s4;

endmodule

FILE: rtl/cts_final.sv
// adds the last term, rounds to q2.30 and saturates
`timescale 1ns / 1ps

module cts_final import cts_pkg::*; #(
	parameter int LAST_IDX = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  term_bus_t        bus_in,
	output logic             out_valid,
	output logic [COS_W-1:0] cosine
);

	localparam bit SUB_LAST = (LAST_IDX % 2) == 1;

	logic             valid_s1, valid_s2;
	logic [SUM_W-1:0] sum_s1;
	logic [SUM_W-1:0] sum_rnd;
	logic [COS_W-1:0] cos_next;
	logic [COS_W-1:0] cos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= bus_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	assign sum_rnd = sum_s1 + SUM_W'(2);

	always_comb begin
		if ($signed(sum_s1) >= $signed(SAT_HI_LIM)) begin
			cos_next = COS_MAX;
		end else if ($signed(sum_s1) < $signed(SAT_LO_LIM)) begin
			cos_next = COS_MIN;
		end else begin
			cos_next = sum_rnd[2 +: COS_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= SUB_LAST ? (bus_in.sum - bus_in.mag) : (bus_in.sum + bus_in.mag);
			cos_s2 <= cos_next;
		end
	end

	assign out_valid = valid_s2;
	assign cosine    = cos_s2;

endmodule

FILE: tb/tb_cosine_taylor_series.sv
// self-checking testbench for the taylor series cosine pipeline
`timescale 1ns / 1ps

module tb_cosine_taylor_series import cts_pkg::*;;

	localparam int NUM_TERMS = 10;
	localparam int LATENCY = 4 * NUM_TERMS;
	localparam int RANDOM_ITEMS = 1280;
	localparam int IDLE_PCT = 19;
	localparam int HOLDOFF_AT = 300;
	localparam int HOLDOFF_CYCLES = 160;
	localparam int QUIET_FIRST = 700;
	localparam int QUIET_LAST = 1000;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 32'sd843314857;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 32'sd421657428;
	localparam logic signed [ANGLE_W-1:0] ANGLE_ONE = 32'sd268435456;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic angle_valid = 1'b0;
	logic angle_stall;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic cosine_valid;
	logic cosine_stall = 1'b0;
	logic signed [COS_W-1:0] cosine;

	logic signed [ANGLE_W-1:0] pending_angles[$];
	logic signed [COS_W-1:0] expected_cosines[$];
	logic signed [COS_W-1:0] want_cosine;
	int accepted_count = 0;
	int received_count = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit holdoff_done = 1'b0;

	cosine_taylor_series #(
		.NUM_TERMS(NUM_TERMS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.angle_valid(angle_valid),
		.angle_stall(angle_stall),
		.angle(angle),
		.cosine_valid(cosine_valid),
		.cosine_stall(cosine_stall),
		.cosine(cosine)
	);

	// round(a * b / 2^32), half up
	function automatic logic [63:0] scaled_product(input logic [63:0] a,
			input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b} + (128'd1 << 31);
		return prod[95:32];
	endfunction

	function automatic logic signed [COS_W-1:0] cosine_of(input logic signed [ANGLE_W-1:0] a);
		logic [63:0] mag_x;
		logic [63:0] x2q;
		logic [63:0] term;
		logic [63:0] recip;
		logic signed [63:0] acc;
		logic signed [63:0] rounded;
		int term_count;
		term_count = NUM_TERMS > 11 ? 11 : (NUM_TERMS < 1 ? 1 : NUM_TERMS);
		mag_x = a[ANGLE_W-1] ? 64'h1_0000_0000 - {32'd0, a} : {32'd0, a};
		x2q = (mag_x * mag_x + (64'd1 << 23)) >> 24;
		term = 64'd1 << 32;
		acc = 64'sh1_0000_0000;
		for (int n = 1; n < term_count; n++) begin
			recip = ((64'd1 << 33) / (64'(2 * n - 1) * 64'(2 * n)) + 64'd1) >> 1;
			term = scaled_product(scaled_product(term, x2q), recip);
			if (n % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc >= 64'sh1_FFFF_FFFE) begin
			return 32'h7FFF_FFFF;
		end
		if (acc < -64'sh2_0000_0000) begin
			return 32'h8000_0000;
		end
		rounded = (acc + 64'sd2) >>> 2;
		return rounded[COS_W-1:0];
	endfunction

	function automatic bit idle_roll(input bit quiet);
		return !quiet && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic logic signed [ANGLE_W-1:0] random_angle();
		if ($urandom_range(1) == 1) begin
			return $urandom();
		end
		return int'($urandom_range(2 * 843314857)) - int'(ANGLE_PI);
	endfunction

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_angles.size() != 0 || angle_valid || expected_cosines.size() != 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid <= 1'b0;
			angle <= '0;
		end else begin
			if (angle_valid && !angle_stall) begin
				expected_cosines.push_back(cosine_of(angle));
				accepted_count++;
			end
			if (!(angle_valid && angle_stall)) begin
				if (pending_angles.size() != 0 &&
						!idle_roll(accepted_count >= QUIET_FIRST &&
						accepted_count < QUIET_LAST)) begin
					angle <= pending_angles.pop_front();
					angle_valid <= 1'b1;
				end else begin
					angle_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cosine_stall <= 1'b0;
		end else begin
			if (cosine_valid && !cosine_stall) begin
				received_count++;
				if (expected_cosines.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("unexpected cosine %h with nothing pending", cosine);
					end
				end else begin
					want_cosine = expected_cosines.pop_front();
					if (cosine !== want_cosine) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("cosine mismatch #%0d: expected %h actual %h",
								received_count, want_cosine, cosine);
						end
					end
				end
			end
			if (hold_left != 0) begin
				cosine_stall <= 1'b1;
				hold_left--;
			end else if (!holdoff_done && received_count >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				hold_left = HOLDOFF_CYCLES - 1;
				cosine_stall <= 1'b1;
			end else begin
				cosine_stall <= idle_roll(received_count >= QUIET_FIRST &&
					received_count < QUIET_LAST);
			end
		end
	end

	initial begin
		// zero, extremes, quarter and half turns, large angles
		pending_angles.push_back(32'sd0);
		pending_angles.push_back(32'sd1);
		pending_angles.push_back(-32'sd1);
		pending_angles.push_back(32'sh7FFF_FFFF);
		pending_angles.push_back(32'sh8000_0000);
		pending_angles.push_back(32'sh8000_0001);
		pending_angles.push_back(ANGLE_PI);
		pending_angles.push_back(-ANGLE_PI);
		pending_angles.push_back(ANGLE_HALF_PI);
		pending_angles.push_back(-ANGLE_HALF_PI);
		pending_angles.push_back(ANGLE_ONE);
		pending_angles.push_back(-ANGLE_ONE);
		pending_angles.push_back(32'sh4000_0000);
		pending_angles.push_back(32'shC000_0000);
		pending_angles.push_back(32'sh6000_0000);
		pending_angles.push_back(32'shB000_0000);
		pending_angles.push_back(32'sh7800_0000);
		pending_angles.push_back(32'sh5555_5555);
		pending_angles.push_back(32'shAAAA_AAAA);
		pending_angles.push_back(32'sh0000_1000);
		pending_angles.push_back(32'shFFFF_F000);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		for (int half = 0; half < 2; half++) begin
			for (int i = 0; i < RANDOM_ITEMS / 2; i++) begin
				pending_angles.push_back(random_angle());
			end
			wait_drained();
		end
		repeat (LATENCY + 10) @(negedge clk);
		if (mismatch_count == 0 && expected_cosines.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
